// ----- hdl/adc_window_insulation_monitor_unit_defines.svh -----
// Assertion macros shared by the insulation monitor RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef ADC_WINDOW_INSULATION_MONITOR_UNIT_DEFINES_SVH
`define ADC_WINDOW_INSULATION_MONITOR_UNIT_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define AWIM_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define AWIM_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/awim_pkg.sv -----
// Types, widths and constants of the ADC window insulation monitor.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package awim_pkg;

    localparam int SAMPLES_PER_WINDOW = 6;
    localparam int ADC_BITS           = 12;
    localparam int NUM_CH             = 5;

    localparam int CH_VT1 = 0;
    localparam int CH_VT2 = 1;
    localparam int CH_CC  = 2;
    localparam int CH_TM  = 3;
    localparam int CH_TP  = 4;

    localparam int SUM_W       = ADC_BITS + $clog2(SAMPLES_PER_WINDOW);
    localparam int CNT_W       = $clog2(SAMPLES_PER_WINDOW + 1);
    // sum / N as (sum * ceil(2^s / N)) >> s, exact for sums below 2^SUM_W
    localparam int RECIP_SHIFT = SUM_W + 4;
    localparam int RECIP       = (2 ** RECIP_SHIFT + SAMPLES_PER_WINDOW - 1) / SAMPLES_PER_WINDOW;
    localparam int RECIP_W     = RECIP_SHIFT + 1;
    localparam int PROD_W      = SUM_W + RECIP_W;

    localparam int CFG_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CC_W       = 20;
    localparam int CC_SHIFT   = 8;
    localparam int CCP_W      = CC_SHIFT + CC_W;
    localparam int OFFSET_MIN = 200;
    localparam int RATIO_NUM  = 8475;
    localparam int RATIO_W    = 15;
    localparam int SDIFF_W    = ADC_BITS + 1;
    localparam int LHS_W      = SDIFF_W + RATIO_W;
    localparam int RHS_W      = CFG_W + ADC_BITS;
    localparam int CMP_W      = RHS_W + 2;

    typedef logic [ADC_BITS-1:0]  t_sample;
    typedef logic [SUM_W-1:0]     t_sum;
    typedef logic [CNT_W-1:0]     t_cnt;
    typedef logic [PROD_W-1:0]    t_prod;
    typedef logic [SDIFF_W-1:0]   t_sdiff;
    typedef logic [RATIO_W-1:0]   t_ratio;
    typedef logic [LHS_W-1:0]     t_lhs;
    typedef logic [RHS_W-1:0]     t_rhs;
    typedef logic [CMP_W-1:0]     t_cmp;
    typedef logic [CCP_W-1:0]     t_ccp;
    typedef logic [CC_W-1:0]      t_cc;
    typedef logic [CFG_W-1:0]     t_cfg;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    typedef logic [1:0]           t_phase;

    localparam t_cnt     WIN_FULL          = t_cnt'(SAMPLES_PER_WINDOW);
    localparam t_prod    RECIP_K           = t_prod'(RECIP);
    localparam t_ratio   RATIO_K           = t_ratio'(RATIO_NUM);
    localparam t_sample  OFFSET_K          = t_sample'(OFFSET_MIN);
    localparam t_cfg     CHECK_VOLTAGE_RST = t_cfg'(500);
    localparam t_cfg     CC_GAIN_RST       = t_cfg'(256);
    localparam t_cfg_idx REG_CHECK_VOLTAGE = t_cfg_idx'(0);
    localparam t_cfg_idx REG_CC_GAIN       = t_cfg_idx'(1);

    localparam t_phase PH_IDLE   = 2'd0;
    localparam t_phase PH_SETTLE = 2'd1;
    localparam t_phase PH_ARMED  = 2'd2;

    typedef struct packed {
        t_sample vt1_sample;
        t_sample vt2_sample;
        t_sample cc_sample;
        t_sample temp_minus_sample;
        t_sample temp_plus_sample;
        logic    start_check;
    } t_in;

    typedef struct packed {
        logic    window_done;
        t_sample vt1_average;
        t_sample vt2_average;
        t_cc     cc_value;
        t_sample temp_minus_average;
        t_sample temp_plus_average;
        logic    insulation_fault;
        logic    relay_closed;
    } t_out;

    typedef struct packed {
        logic close;
        logic start_check;
        logic do_check;
        logic cal_store;
    } t_ctl;

    typedef struct packed {
        t_ctl                   ctl;
        logic [NUM_CH-1:0][SUM_W-1:0] sums;
    } t_s1;

    typedef struct packed {
        t_ctl                          ctl;
        logic [NUM_CH-1:0][ADC_BITS-1:0] avg;
    } t_s2;

    typedef struct packed {
        t_ctl    ctl;
        t_sample vt1_avg;
        t_sample vt2_avg;
        t_cc     cc_value;
        t_sample tm_avg;
        t_sample tp_avg;
        t_lhs    lhs;
        t_rhs    rhs;
        logic    off_fail;
        logic    div_nz;
    } t_s3;

endpackage

// ----- hdl/awim_accum.sv -----
// Window accumulator: per-channel sums, window counter and check sequencing.
// Depends on awim_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "adc_window_insulation_monitor_unit_defines.svh"

module awim_accum (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  awim_pkg::t_in i_item,
    output logic          o_valid,
    input  logic          i_dn_ready,
    output awim_pkg::t_s1 o_s1
);

    awim_pkg::t_cnt    r_count;
    awim_pkg::t_sum    r_sums [awim_pkg::NUM_CH];
    awim_pkg::t_phase  r_phase;
    logic              r_calibrated;
    logic              r_valid;
    awim_pkg::t_s1     r_s1;

    awim_pkg::t_phase  n_phase;
    awim_pkg::t_phase  w_phase_a;
    awim_pkg::t_sample w_samp [awim_pkg::NUM_CH];
    logic              w_adv;
    logic              w_acc;
    logic              w_close;
    logic              w_check;

    assign w_adv   = !r_valid || i_dn_ready;
    assign w_acc   = i_valid && w_adv;
    assign o_stall = !w_adv;
    assign o_valid = r_valid;
    assign o_s1    = r_s1;

    assign w_samp[awim_pkg::CH_VT1] = i_item.vt1_sample;
    assign w_samp[awim_pkg::CH_VT2] = i_item.vt2_sample;
    assign w_samp[awim_pkg::CH_CC]  = i_item.cc_sample;
    assign w_samp[awim_pkg::CH_TM]  = i_item.temp_minus_sample;
    assign w_samp[awim_pkg::CH_TP]  = i_item.temp_plus_sample;

    assign w_close   = r_count >= awim_pkg::WIN_FULL;
    assign w_phase_a = i_item.start_check ? awim_pkg::PH_SETTLE : r_phase;

    always_comb begin
        n_phase = w_phase_a;
        w_check = 1'b0;
        unique case (w_phase_a)
            awim_pkg::PH_IDLE: begin
                n_phase = awim_pkg::PH_IDLE;
            end
            awim_pkg::PH_SETTLE: begin
                n_phase = w_close ? awim_pkg::PH_ARMED : awim_pkg::PH_SETTLE;
            end
            default: begin
                n_phase = w_close ? awim_pkg::PH_IDLE : w_phase_a;
                w_check = w_close;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_phase      <= awim_pkg::PH_IDLE;
            r_calibrated <= 1'b0;
            r_valid      <= 1'b0;
            for (int c = 0; c < awim_pkg::NUM_CH; c++) begin
                r_sums[c] <= '0;
            end
        end else begin
            if (w_adv) begin
                r_valid <= i_valid;
            end
            if (w_acc) begin
                r_phase <= n_phase;
                if (w_close) begin
                    r_count      <= '0;
                    r_calibrated <= 1'b1;
                end else begin
                    r_count <= r_count + awim_pkg::t_cnt'(1);
                end
                for (int c = 0; c < awim_pkg::NUM_CH; c++) begin
                    r_sums[c] <= w_close ? '0 : r_sums[c] + awim_pkg::t_sum'(w_samp[c]);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_s1.ctl.close       <= w_close;
            r_s1.ctl.start_check <= i_item.start_check;
            r_s1.ctl.do_check    <= w_check;
            r_s1.ctl.cal_store   <= w_close && !r_calibrated;
            for (int c = 0; c < awim_pkg::NUM_CH; c++) begin
                r_s1.sums[c] <= r_sums[c];
            end
        end
    end

    `AWIM_ASSERT_IMP(a_count_range, i_clk, i_rst_n, 1'b1, r_count <= awim_pkg::WIN_FULL, "window count overran")
    `AWIM_ASSERT_NXT(a_close_clears, i_clk, i_rst_n, w_acc && w_close, (r_count == '0) && (r_sums[awim_pkg::CH_VT1] == '0), "window close did not clear")

endmodule

// ----- hdl/awim_avg.sv -----
// Average stage: divides each window sum by the window length.
// Depends on awim_pkg.
`timescale 1ns / 1ps

module awim_avg (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_up_ready,
    input  awim_pkg::t_s1 i_s1,
    output logic          o_valid,
    input  logic          i_dn_ready,
    output awim_pkg::t_s2 o_s2
);

    logic              r_valid;
    awim_pkg::t_s2     r_s2;
    awim_pkg::t_prod   w_prod [awim_pkg::NUM_CH];
    logic              w_adv;

    assign w_adv      = !r_valid || i_dn_ready;
    assign o_up_ready = w_adv;
    assign o_valid    = r_valid;
    assign o_s2       = r_s2;

    always_comb begin
        for (int c = 0; c < awim_pkg::NUM_CH; c++) begin
            w_prod[c] = awim_pkg::t_prod'(i_s1.sums[c]) * awim_pkg::RECIP_K;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && i_valid) begin
            r_s2.ctl <= i_s1.ctl;
            for (int c = 0; c < awim_pkg::NUM_CH; c++) begin
                r_s2.avg[c] <= w_prod[c][awim_pkg::RECIP_SHIFT +: awim_pkg::ADC_BITS];
            end
        end
    end

endmodule

// ----- hdl/awim_calc.sv -----
// Check arithmetic stage: calibration store, offsets, cross products, CC scaling.
// Depends on awim_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "adc_window_insulation_monitor_unit_defines.svh"

module awim_calc (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_up_ready,
    input  awim_pkg::t_s2  i_s2,
    input  awim_pkg::t_cfg i_check_voltage,
    input  awim_pkg::t_cfg i_cc_gain,
    output logic           o_valid,
    input  logic           i_dn_ready,
    output awim_pkg::t_s3  o_s3
);

    logic                 r_valid;
    awim_pkg::t_s3        r_s3;
    awim_pkg::t_sample    r_cal [2];

    awim_pkg::t_sdiff     w_a1;
    awim_pkg::t_sdiff     w_a2;
    awim_pkg::t_sdiff     w_d;
    awim_pkg::t_sdiff     w_neg_d;
    awim_pkg::t_sdiff     w_diff1;
    awim_pkg::t_sdiff     w_diff2;
    awim_pkg::t_sdiff     w_off;
    awim_pkg::t_sdiff     w_num;
    awim_pkg::t_sample    w_mag;
    logic signed [awim_pkg::LHS_W-1:0] w_lhs;
    awim_pkg::t_rhs       w_rhs;
    awim_pkg::t_ccp       w_ccp;
    logic                 w_pos;
    logic                 w_off_fail;
    logic                 w_adv;
    logic                 w_load;

    assign w_adv      = !r_valid || i_dn_ready;
    assign w_load     = w_adv && i_valid;
    assign o_up_ready = w_adv;
    assign o_valid    = r_valid;
    assign o_s3       = r_s3;

    // larger side picks which offset is tested and which feeds the ratio
    assign w_a1    = {1'b0, i_s2.avg[awim_pkg::CH_VT1]};
    assign w_a2    = {1'b0, i_s2.avg[awim_pkg::CH_VT2]};
    assign w_d     = w_a1 - w_a2;
    assign w_neg_d = awim_pkg::t_sdiff'(0) - w_d;
    assign w_pos   = !w_d[awim_pkg::SDIFF_W-1] && (w_d != '0);
    assign w_diff1 = w_a1 - {1'b0, r_cal[0]};
    assign w_diff2 = w_a2 - {1'b0, r_cal[1]};
    assign w_off   = w_pos ? w_diff1 : w_diff2;
    assign w_num   = w_pos ? w_diff2 : w_diff1;
    assign w_mag   = w_pos ? w_d[awim_pkg::ADC_BITS-1:0] : w_neg_d[awim_pkg::ADC_BITS-1:0];

    assign w_off_fail = w_off[awim_pkg::SDIFF_W-1] ||
                        (w_off[awim_pkg::ADC_BITS-1:0] < awim_pkg::OFFSET_K);
    assign w_lhs = $signed(w_num) * $signed(awim_pkg::RATIO_K);
    assign w_rhs = awim_pkg::t_rhs'(i_check_voltage) * awim_pkg::t_rhs'(w_mag);
    assign w_ccp = awim_pkg::t_ccp'(i_s2.avg[awim_pkg::CH_CC]) * awim_pkg::t_ccp'(i_cc_gain);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_cal[0] <= '0;
            r_cal[1] <= '0;
        end else begin
            if (w_adv) begin
                r_valid <= i_valid;
            end
            if (w_load && i_s2.ctl.cal_store) begin
                r_cal[0] <= i_s2.avg[awim_pkg::CH_VT1];
                r_cal[1] <= i_s2.avg[awim_pkg::CH_VT2];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_s3.ctl      <= i_s2.ctl;
            r_s3.vt1_avg  <= i_s2.avg[awim_pkg::CH_VT1];
            r_s3.vt2_avg  <= i_s2.avg[awim_pkg::CH_VT2];
            r_s3.cc_value <= w_ccp[awim_pkg::CC_SHIFT +: awim_pkg::CC_W];
            r_s3.tm_avg   <= i_s2.avg[awim_pkg::CH_TM];
            r_s3.tp_avg   <= i_s2.avg[awim_pkg::CH_TP];
            r_s3.lhs      <= w_lhs;
            r_s3.rhs      <= w_rhs;
            r_s3.off_fail <= w_off_fail;
            r_s3.div_nz   <= w_d != '0;
        end
    end

    `AWIM_ASSERT_IMP(a_cal_not_check, i_clk, i_rst_n, i_valid && i_s2.ctl.cal_store, !i_s2.ctl.do_check, "calibration and check in one window")

endmodule

// ----- hdl/adc_window_insulation_monitor_unit.sv -----
// Top level of the ADC window insulation monitor: config registers, pipeline, result stage.
// Depends on awim_pkg, awim_accum, awim_avg, awim_calc and the assertion macro header.
`timescale 1ns / 1ps
`include "adc_window_insulation_monitor_unit_defines.svh"

// Takes one five-channel ADC scan per item and returns one result item per item, at one
// item per clock when not stalled, through the registered stages accumulate, divide by
// the window length, check products and CC scaling, then the result register, which also
// holds the latched averages, fault and relay state. Every result shows the state after
// its item; window_done marks the item that closed a six-scan window. The first window
// sets calibration, a start request closes the relay and clears the fault, and the second
// window closed after it runs the check and opens the relay. check_voltage and cc_gain
// must be written through the config port only while idle; the block does not enforce it.
module adc_window_insulation_monitor_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  awim_pkg::t_in      i_item,
    output logic               o_valid,
    input  logic               i_stall,
    output awim_pkg::t_out     o_item,
    input  logic               i_cfg_we,
    input  awim_pkg::t_cfg_idx i_cfg_index,
    input  awim_pkg::t_cfg     i_cfg_data
);

    awim_pkg::t_cfg r_check_voltage;
    awim_pkg::t_cfg r_cc_gain;
    logic           r_ovalid;
    awim_pkg::t_out r_out;
    awim_pkg::t_out n_out;

    logic           w_s1_valid;
    logic           w_s2_valid;
    logic           w_s3_valid;
    logic           w_s2_ready;
    logic           w_s3_ready;
    logic           w_out_adv;
    logic           w_out_load;
    logic           w_fail;
    logic           w_ratio_fail;
    awim_pkg::t_s1  w_s1;
    awim_pkg::t_s2  w_s2;
    awim_pkg::t_s3  w_s3;
    awim_pkg::t_cmp w_lhs_x;
    awim_pkg::t_cmp w_rhs_x;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_check_voltage <= awim_pkg::CHECK_VOLTAGE_RST;
            r_cc_gain       <= awim_pkg::CC_GAIN_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                awim_pkg::REG_CHECK_VOLTAGE: r_check_voltage <= i_cfg_data;
                awim_pkg::REG_CC_GAIN:       r_cc_gain       <= i_cfg_data;
                default: ;
            endcase
        end
    end

    awim_accum u_accum (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_item     (i_item),
        .o_valid    (w_s1_valid),
        .i_dn_ready (w_s2_ready),
        .o_s1       (w_s1)
    );

    awim_avg u_avg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_s1_valid),
        .o_up_ready (w_s2_ready),
        .i_s1       (w_s1),
        .o_valid    (w_s2_valid),
        .i_dn_ready (w_s3_ready),
        .o_s2       (w_s2)
    );

    awim_calc u_calc (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (w_s2_valid),
        .o_up_ready      (w_s3_ready),
        .i_s2            (w_s2),
        .i_check_voltage (r_check_voltage),
        .i_cc_gain       (r_cc_gain),
        .o_valid         (w_s3_valid),
        .i_dn_ready      (w_out_adv),
        .o_s3            (w_s3)
    );

    assign w_out_adv  = !r_ovalid || !i_stall;
    assign w_out_load = w_out_adv && w_s3_valid;

    // signed lhs against 2 * check_voltage * |d|
    assign w_lhs_x = {{(awim_pkg::CMP_W - awim_pkg::LHS_W){w_s3.lhs[awim_pkg::LHS_W-1]}},
                      w_s3.lhs};
    assign w_rhs_x = {1'b0, w_s3.rhs, 1'b0};
    assign w_ratio_fail = w_s3.div_nz && ($signed(w_lhs_x) < $signed(w_rhs_x));
    assign w_fail       = w_s3.ctl.do_check && (w_s3.off_fail || w_ratio_fail);

    always_comb begin
        n_out             = r_out;
        n_out.window_done = w_s3.ctl.close;
        if (w_s3.ctl.close) begin
            n_out.cc_value           = w_s3.cc_value;
            n_out.temp_minus_average = w_s3.tm_avg;
            n_out.temp_plus_average  = w_s3.tp_avg;
        end
        if (w_s3.ctl.do_check) begin
            n_out.vt1_average = w_s3.vt1_avg;
            n_out.vt2_average = w_s3.vt2_avg;
        end
        n_out.insulation_fault = (r_out.insulation_fault && !w_s3.ctl.start_check) || w_fail;
        if (w_s3.ctl.start_check) begin
            n_out.relay_closed = 1'b1;
        end else if (w_s3.ctl.do_check) begin
            n_out.relay_closed = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
            r_out    <= '0;
        end else if (w_out_adv) begin
            r_ovalid <= w_s3_valid;
            if (w_s3_valid) begin
                r_out <= n_out;
            end
        end
    end

    assign o_valid = r_ovalid;
    assign o_item  = r_out;

    `AWIM_ASSERT_IMP(a_check_on_close, i_clk, i_rst_n, w_s3_valid && w_s3.ctl.do_check, w_s3.ctl.close, "check outside a window close")
    `AWIM_ASSERT_NXT(a_check_opens_relay, i_clk, i_rst_n, w_out_load && w_s3.ctl.do_check, !r_out.relay_closed, "relay still closed after check")
    `AWIM_ASSERT_NXT(a_start_arms, i_clk, i_rst_n, w_out_load && w_s3.ctl.start_check, r_out.relay_closed && !r_out.insulation_fault, "start did not close relay or clear fault")

endmodule
